// ===== src/dsmf_pkg.sv =====
`default_nettype none

package dsmf_pkg;

	localparam int TYPE_MAX_DEF    = 6;
	localparam int PAYLOAD_MAX_DEF = 100;

	localparam logic [7:0] CH_START = 8'h24;	// '$'
	localparam logic [7:0] CH_SEP   = 8'h2C;	// ','
	localparam logic [7:0] CH_END   = 8'h2A;	// '*'

	localparam int EV_W   = 3;
	localparam int POS_W  = 7;
	localparam int CHAR_W = 8;
	localparam int TLEN_W = 3;
	localparam int PLEN_W = 7;
	localparam int OUT_W  = EV_W + POS_W + CHAR_W + TLEN_W + PLEN_W;
	localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		PH_WAIT    = 2'd0,
		PH_TYPE    = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [EV_W-1:0] {
		EV_NONE    = 3'd0,
		EV_TYPE    = 3'd1,
		EV_PAYLOAD = 3'd2,
		EV_DONE    = 3'd3,
		EV_ABORT   = 3'd4
	} event_t;

endpackage

`default_nettype wire

// ===== src/dollar_star_message_framer.sv =====
// A byte accepted on s_axis is held in the input register, and its result then in the result register on m_axis.
// Throughput: one byte per cycle while m_axis_tready stays high; an input register and a result register
// let a new byte enter while the previous result still waits on m_axis.
// Reset (arst_n low, asynchronous): both stages empty, framer waits for '$',
// both character counts cleared.
`default_nettype none

module dollar_star_message_framer #(
	parameter int TYPE_MAX    = dsmf_pkg::TYPE_MAX_DEF,
	parameter int PAYLOAD_MAX = dsmf_pkg::PAYLOAD_MAX_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [7:0]                        s_axis_tdata,	// byte_value
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// event_res[2:0], position[9:3], char_out[17:10], type_length[20:18],
	// payload_length[27:21], zero fill above
	output logic [dsmf_pkg::OUT_BYTES_W-1:0]       m_axis_tdata
);

	localparam int TW = $clog2(TYPE_MAX + 1);
	localparam int PW = $clog2(PAYLOAD_MAX + 1);
	localparam logic [TW-1:0] TYPE_LIM = TW'(TYPE_MAX);
	localparam logic [PW-1:0] PAY_LIM  = PW'(PAYLOAD_MAX);

	// input stage
	logic       v_s1;
	logic [7:0] byte_s1;

	// result stage
	logic                           v_s2;
	dsmf_pkg::event_t               ev_s2;
	logic [dsmf_pkg::POS_W-1:0]     pos_s2;
	logic [dsmf_pkg::CHAR_W-1:0]    ch_s2;
	logic [dsmf_pkg::TLEN_W-1:0]    tlen_s2;
	logic [dsmf_pkg::PLEN_W-1:0]    plen_s2;

	// framer state
	dsmf_pkg::phase_t phase_q, phase_d;
	logic [TW-1:0]    tcnt_q, tcnt_d;
	logic [PW-1:0]    pcnt_q, pcnt_d;

	dsmf_pkg::event_t            ev_d;
	logic [dsmf_pkg::POS_W-1:0]  pos_d;
	logic [dsmf_pkg::CHAR_W-1:0] ch_d;
	logic [dsmf_pkg::TLEN_W-1:0] tlen_d;
	logic [dsmf_pkg::PLEN_W-1:0] plen_d;

	logic adv;
	logic step;

	assign adv           = !v_s2 || m_axis_tready;
	assign step          = v_s1 && adv;
	assign s_axis_tready = !v_s1 || adv;
	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {{(dsmf_pkg::OUT_BYTES_W - dsmf_pkg::OUT_W){1'b0}},
		plen_s2, tlen_s2, ch_s2, pos_s2, ev_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dsmf_pkg::PH_WAIT;
			tcnt_q  <= '0;
			pcnt_q  <= '0;
			v_s2    <= 1'b0;
		end else begin
			if (adv) begin
				v_s2 <= v_s1;
			end
			if (step) begin
				phase_q <= phase_d;
				tcnt_q  <= tcnt_d;
				pcnt_q  <= pcnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ev_s2   <= ev_d;
			pos_s2  <= pos_d;
			ch_s2   <= ch_d;
			tlen_s2 <= tlen_d;
			plen_s2 <= plen_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		tcnt_d  = tcnt_q;
		pcnt_d  = pcnt_q;
		ev_d    = dsmf_pkg::EV_NONE;
		pos_d   = '0;
		ch_d    = '0;
		tlen_d  = '0;
		plen_d  = '0;
		case (phase_q)
			dsmf_pkg::PH_TYPE: begin
				if (byte_s1 == dsmf_pkg::CH_SEP) begin
					phase_d = dsmf_pkg::PH_PAYLOAD;
					pcnt_d  = '0;
				end else if (tcnt_q >= TYPE_LIM) begin
					// separator still allowed at the limit, anything else aborts
					phase_d = dsmf_pkg::PH_WAIT;
					tcnt_d  = '0;
					ev_d    = dsmf_pkg::EV_ABORT;
				end else if (byte_s1 == dsmf_pkg::CH_END) begin
					phase_d = dsmf_pkg::PH_WAIT;
					ev_d    = dsmf_pkg::EV_DONE;
					tlen_d  = dsmf_pkg::TLEN_W'(tcnt_q);
				end else begin
					ev_d   = dsmf_pkg::EV_TYPE;
					pos_d  = dsmf_pkg::POS_W'(tcnt_q);
					ch_d   = byte_s1;
					tcnt_d = tcnt_q + 1'b1;
				end
			end
			dsmf_pkg::PH_PAYLOAD: begin
				if (byte_s1 == dsmf_pkg::CH_END) begin
					phase_d = dsmf_pkg::PH_WAIT;
					ev_d    = dsmf_pkg::EV_DONE;
					tlen_d  = dsmf_pkg::TLEN_W'(tcnt_q);
					plen_d  = dsmf_pkg::PLEN_W'(pcnt_q);
				end else if (pcnt_q >= PAY_LIM) begin
					phase_d = dsmf_pkg::PH_WAIT;
					pcnt_d  = '0;
					ev_d    = dsmf_pkg::EV_ABORT;
				end else begin
					ev_d   = dsmf_pkg::EV_PAYLOAD;
					pos_d  = dsmf_pkg::POS_W'(pcnt_q);
					ch_d   = byte_s1;
					pcnt_d = pcnt_q + 1'b1;
				end
			end
			default: begin
				phase_d = dsmf_pkg::PH_WAIT;
				if (byte_s1 == dsmf_pkg::CH_START) begin
					phase_d = dsmf_pkg::PH_TYPE;
					tcnt_d  = '0;
				end
			end
		endcase
	end

	a_tcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tcnt_q <= TYPE_LIM)
		else $error("type count beyond limit");

	a_pcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= PAY_LIM)
		else $error("payload count beyond limit");

	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> v_s2)
		else $error("processed byte produced no result");

	a_store_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(step && ev_d == dsmf_pkg::EV_PAYLOAD) |=> (pcnt_q == $past(pcnt_q) + 1'b1))
		else $error("payload count did not advance on store");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TYPE_LIMIT    = dsmf_pkg::TYPE_MAX_DEF;
	localparam int PAYLOAD_LIMIT = dsmf_pkg::PAYLOAD_MAX_DEF;
	localparam int RANDOM_BYTES  = 1000;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int MAX_REPORTS   = 10;

	// lowest field in the lowest bits, same as m_axis_tdata
	typedef struct packed {
		logic [dsmf_pkg::PLEN_W-1:0] payload_length;
		logic [dsmf_pkg::TLEN_W-1:0] type_length;
		logic [dsmf_pkg::CHAR_W-1:0] char_out;
		logic [dsmf_pkg::POS_W-1:0]  position;
		dsmf_pkg::event_t            ev;
	} framer_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic [7:0] s_axis_tdata = 8'h00;
	logic s_axis_tready;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [dsmf_pkg::OUT_BYTES_W-1:0] m_axis_tdata;

	dollar_star_message_framer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	// framer state as the testbench sees it
	dsmf_pkg::phase_t frm_phase = dsmf_pkg::PH_WAIT;
	int type_cnt = 0;
	int payload_cnt = 0;

	framer_event_t pending_events[$];
	int mismatches = 0;
	int cycle_count = 0;
	int burst_left = 0;

	function automatic framer_event_t predict_framer_event(input logic [7:0] b);
		framer_event_t r = '0;
		case (frm_phase)
			dsmf_pkg::PH_TYPE: begin
				if (b == dsmf_pkg::CH_SEP) begin
					frm_phase = dsmf_pkg::PH_PAYLOAD;
					payload_cnt = 0;
				end else if (type_cnt >= TYPE_LIMIT) begin
					frm_phase = dsmf_pkg::PH_WAIT;
					type_cnt = 0;
					r.ev = dsmf_pkg::EV_ABORT;
				end else if (b == dsmf_pkg::CH_END) begin
					frm_phase = dsmf_pkg::PH_WAIT;
					r.ev = dsmf_pkg::EV_DONE;
					r.type_length = type_cnt[dsmf_pkg::TLEN_W-1:0];
				end else begin
					r.ev = dsmf_pkg::EV_TYPE;
					r.position = type_cnt[dsmf_pkg::POS_W-1:0];
					r.char_out = b;
					type_cnt++;
				end
			end
			dsmf_pkg::PH_PAYLOAD: begin
				if (b == dsmf_pkg::CH_END) begin
					frm_phase = dsmf_pkg::PH_WAIT;
					r.ev = dsmf_pkg::EV_DONE;
					r.type_length = type_cnt[dsmf_pkg::TLEN_W-1:0];
					r.payload_length = payload_cnt[dsmf_pkg::PLEN_W-1:0];
				end else if (payload_cnt >= PAYLOAD_LIMIT) begin
					// aborting byte is dropped
					frm_phase = dsmf_pkg::PH_WAIT;
					payload_cnt = 0;
					r.ev = dsmf_pkg::EV_ABORT;
				end else begin
					r.ev = dsmf_pkg::EV_PAYLOAD;
					r.position = payload_cnt[dsmf_pkg::POS_W-1:0];
					r.char_out = b;
					payload_cnt++;
				end
			end
			default: begin
				frm_phase = dsmf_pkg::PH_WAIT;
				if (b == dsmf_pkg::CH_START) begin
					frm_phase = dsmf_pkg::PH_TYPE;
					type_cnt = 0;
				end
			end
		endcase
		return r;
	endfunction

	// predict on input transactions, check on output transactions
	always @(posedge clk) begin
		framer_event_t got;
		framer_event_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				pending_events.push_back(predict_framer_event(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[dsmf_pkg::OUT_W-1:0];
				if (pending_events.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"unexpected result: ",
							"ev=%0d pos=%0d ch=%02h tlen=%0d plen=%0d"},
							got.ev, got.position, got.char_out, got.type_length,
							got.payload_length);
				end else begin
					want = pending_events.pop_front();
					if (got.ev !== want.ev || got.position !== want.position ||
					    got.char_out !== want.char_out ||
					    got.type_length !== want.type_length ||
					    got.payload_length !== want.payload_length) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"mismatch: exp ev=%0d pos=%0d ch=%02h ",
								"tlen=%0d plen=%0d, got ev=%0d pos=%0d ch=%02h ",
								"tlen=%0d plen=%0d"},
								want.ev, want.position, want.char_out, want.type_length,
								want.payload_length, got.ev, got.position, got.char_out,
								got.type_length, got.payload_length);
					end
				end
			end
		end
	end

	// receiver stalls: the mode is redrawn whenever its random countdown runs out
	int rx_mode = 0;
	int rx_left = 0;
	int rx_tick = 0;
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(16, 200);
		end else begin
			rx_left--;
		end
		rx_tick++;
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= (rx_tick % 7) < 3;
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// one input transaction; idles between bursts afterwards
	task automatic send_byte(input logic [7:0] b);
		s_axis_tdata <= b;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 20);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_str(input string s);
		foreach (s[i])
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] body_byte(input logic [7:0] excl_a, input logic [7:0] excl_b);
		logic [7:0] b;
		do
			b = $urandom_range(0, 255);
		while (b == excl_a || b == excl_b);
		return b;
	endfunction

	task automatic test_idle_bytes();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(dsmf_pkg::CH_END);
	endtask

	task automatic test_empty_messages();
		send_str("$*");      // no type, no payload
		send_str("$,*");     // separator right away
	endtask

	task automatic test_type_limit();
		// full type, separator still taken; extreme bytes and start marker in payload, end marker closes
		send_str("$ABCDEF,");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(dsmf_pkg::CH_START);
		send_byte(dsmf_pkg::CH_END);
		// full type, end marker aborts
		send_str("$ABCDEF*");
	endtask

	task automatic test_payload_limit();
		send_str("$T,");
		repeat (PAYLOAD_LIMIT) send_byte(body_byte(dsmf_pkg::CH_END, dsmf_pkg::CH_END));
		send_byte(dsmf_pkg::CH_END);
		send_str("$T,");
		repeat (PAYLOAD_LIMIT) send_byte(body_byte(dsmf_pkg::CH_END, dsmf_pkg::CH_END));
		send_byte("x");     // over the limit: aborts
	endtask

	// mostly well-formed frames with random content, some broken ones
	task automatic send_random_frame(output int n);
		int junk;
		int type_len;
		int pay_len;
		int ending;
		junk = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
		repeat (junk)
			send_byte($urandom_range(0, 255));
		n = junk;
		send_byte(dsmf_pkg::CH_START);
		n++;
		if ($urandom_range(0, 9) == 0) begin
			repeat (TYPE_LIMIT) send_byte(body_byte(dsmf_pkg::CH_SEP, dsmf_pkg::CH_END));
			send_byte(body_byte(dsmf_pkg::CH_SEP, dsmf_pkg::CH_SEP));
			n += TYPE_LIMIT + 1;
			return;
		end
		type_len = $urandom_range(0, TYPE_LIMIT);
		repeat (type_len) send_byte(body_byte(dsmf_pkg::CH_SEP, dsmf_pkg::CH_END));
		n += type_len;
		ending = $urandom_range(0, 99);
		if (ending < 15) begin
			send_byte(dsmf_pkg::CH_END);
			n++;
			return;
		end else if (ending < 20) begin
			return;   // truncated inside the type
		end
		send_byte(dsmf_pkg::CH_SEP);
		n++;
		pay_len = ($urandom_range(0, 11) == 0) ?
			$urandom_range(PAYLOAD_LIMIT - 3, PAYLOAD_LIMIT + 1) : $urandom_range(0, 20);
		repeat (pay_len) send_byte(body_byte(dsmf_pkg::CH_END, dsmf_pkg::CH_END));
		n += pay_len;
		if (pay_len <= PAYLOAD_LIMIT && $urandom_range(0, 9) != 0) begin
			send_byte(dsmf_pkg::CH_END);
			n++;
		end
	endtask

	task automatic test_random_frames();
		int sent;
		int n;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			send_random_frame(n);
			sent += n;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_bytes();
		test_empty_messages();
		test_type_limit();
		test_payload_limit();
		test_random_frames();
		s_axis_tvalid <= 1'b0;
		// let the monitor log the last input transaction first
		@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== dollar_star_message_framer.f =====
src/dsmf_pkg.sv
src/dollar_star_message_framer.sv
tb/tb_top.sv
